/* sv/code_entry_stepper_sweep_top_macros.svh */
// Assertion macros for the RTL; cess_core.sv includes them.
`ifndef CODE_ENTRY_STEPPER_SWEEP_TOP_MACROS_SVH
`define CODE_ENTRY_STEPPER_SWEEP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CESS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CESS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CESS_ASSERT(lbl, clk, rst, prop, msg)
`define CESS_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

/* sv/cess_pkg.sv */
package cess_pkg;

  localparam int EntryWidth  = 14;
  localparam int KeyWidth    = 5;
  localparam int PosWidth    = 8;
  localparam int TickWidth   = 12;
  localparam int PhaseWidth  = 4;
  localparam int CfgIdxWidth = 2;

  localparam logic [EntryWidth-1:0] ENTRY_MAX = 14'd9999;

  localparam logic [KeyWidth-1:0] KEY_ENTER = 5'd10;
  localparam logic [KeyWidth-1:0] KEY_BACK  = 5'd11;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [CfgIdxWidth-1:0] REG_UNLOCK_CODE  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_TRAVEL_STEPS = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_STEP_TICKS   = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_DWELL_TICKS  = 2'd3;

  localparam logic [EntryWidth-1:0] UNLOCK_CODE_RST  = 14'd1111;
  localparam logic [PosWidth-1:0]   TRAVEL_STEPS_RST = 8'd50;
  localparam logic [TickWidth-1:0]  STEP_TICKS_RST   = 12'd20;
  localparam logic [TickWidth-1:0]  DWELL_TICKS_RST  = 12'd4000;

  typedef struct packed {
    logic                func;
    logic [KeyWidth-1:0] key;
  } in_t;

  typedef struct packed {
    logic [EntryWidth-1:0] entry_value;
    logic [PhaseWidth-1:0] phase;
    logic [PosWidth-1:0]   position;
    logic                  busy_res;
  } out_t;

  typedef struct packed {
    logic [EntryWidth-1:0] unlock_code;
    logic [PosWidth-1:0]   travel_steps;
    logic [TickWidth-1:0]  step_ticks;
    logic [TickWidth-1:0]  dwell_ticks;
  } cfg_t;

  // Exact for every 14-bit value: multiply by 52429 and drop 19 bits.
  function automatic logic [EntryWidth-1:0] div10(input logic [EntryWidth-1:0] x);
    logic [29:0] prod;
    prod = {16'd0, x} * 30'd52429;
    return {3'd0, prod[29:19]};
  endfunction

  function automatic logic [PhaseWidth-1:0] coil_drive(input logic [1:0] p);
    logic [PhaseWidth-1:0] c;
    unique case (p)
      2'd0: c = 4'b0001;
      2'd1: c = 4'b0010;
      2'd2: c = 4'b0100;
      default: c = 4'b1000;
    endcase
    return c;
  endfunction

endpackage

/* sv/cess_core.sv */
`include "code_entry_stepper_sweep_top_macros.svh"

module cess_core
  import cess_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  in_t  word,
  input  cfg_t cfg,
  output out_t res
);

  typedef enum logic [1:0] {MODE_IDLE, MODE_FWD, MODE_DWELL, MODE_REV} mode_t;

  mode_t                 mode, mode_next;
  logic [EntryWidth-1:0] entry_reg, entry_reg_next;
  logic [EntryWidth-1:0] latched_value, latched_value_next;
  logic [PosWidth-1:0]   step_position, step_position_next;
  logic [TickWidth-1:0]  wait_timer, wait_timer_next;
  logic [PhaseWidth-1:0] coil_phase, coil_phase_next;

  logic [17:0]           digit_sum;
  logic [PosWidth-1:0]   base_pos;
  logic [PosWidth-1:0]   pos_up;
  logic [PosWidth-1:0]   pos_down;
  logic                  do_fwd;
  logic                  do_rev;
  logic [TickWidth-1:0]  step_min;
  logic [TickWidth-1:0]  dwell_min;

  assign digit_sum = {1'b0, entry_reg, 3'd0} + {3'd0, entry_reg, 1'b0}
                   + {14'd0, word.key[3:0]};
  assign step_min  = (cfg.step_ticks == '0) ? TickWidth'(1) : cfg.step_ticks;
  assign dwell_min = (cfg.dwell_ticks == '0) ? TickWidth'(1) : cfg.dwell_ticks;
  assign pos_up    = base_pos + PosWidth'(1);
  assign pos_down  = step_position - PosWidth'(1);

  always_comb begin
    mode_next          = mode;
    entry_reg_next     = entry_reg;
    latched_value_next = latched_value;
    step_position_next = step_position;
    wait_timer_next    = wait_timer;
    coil_phase_next    = coil_phase;
    base_pos           = step_position;
    do_fwd             = 1'b0;
    do_rev             = 1'b0;

    if (fire) begin
      if (word.func == FUNC_KEY) begin
        if (mode == MODE_IDLE) begin
          if (word.key < KEY_ENTER) begin
            entry_reg_next = (digit_sum > {4'd0, ENTRY_MAX}) ? ENTRY_MAX
                                                             : digit_sum[EntryWidth-1:0];
          end else if (word.key == KEY_ENTER) begin
            latched_value_next = entry_reg;
            entry_reg_next     = '0;
          end else if (word.key == KEY_BACK) begin
            entry_reg_next = div10(entry_reg);
          end
          if (latched_value_next == cfg.unlock_code) begin
            base_pos = '0;
            do_fwd   = 1'b1;
          end
        end
      end else if (mode != MODE_IDLE) begin
        if (wait_timer > TickWidth'(1)) begin
          wait_timer_next = wait_timer - TickWidth'(1);
        end else begin
          wait_timer_next = '0;
          if (mode == MODE_FWD) begin
            do_fwd = 1'b1;
          end else begin
            do_rev = 1'b1;
          end
        end
      end
    end

    if (do_fwd) begin
      step_position_next = base_pos;
      if (base_pos < cfg.travel_steps) begin
        step_position_next = pos_up;
        coil_phase_next    = coil_drive(pos_up[1:0]);
        mode_next          = MODE_FWD;
        wait_timer_next    = step_min;
      end else begin
        mode_next       = MODE_DWELL;
        wait_timer_next = dwell_min;
      end
    end

    if (do_rev) begin
      if (step_position != '0) begin
        step_position_next = pos_down;
        coil_phase_next    = coil_drive(pos_down[1:0]);
        mode_next          = MODE_REV;
        wait_timer_next    = step_min;
      end else begin
        mode_next          = MODE_IDLE;
        wait_timer_next    = '0;
        latched_value_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      entry_reg     <= '0;
      latched_value <= '0;
      step_position <= '0;
      wait_timer    <= '0;
      coil_phase    <= '0;
    end else begin
      mode          <= mode_next;
      entry_reg     <= entry_reg_next;
      latched_value <= latched_value_next;
      step_position <= step_position_next;
      wait_timer    <= wait_timer_next;
      coil_phase    <= coil_phase_next;
    end
  end

  assign res.entry_value = entry_reg_next;
  assign res.phase       = coil_phase_next;
  assign res.position    = step_position_next;
  assign res.busy_res    = (mode_next != MODE_IDLE);

  `CESS_ASSERT_NEVER(a_entry_range, clk, rst, entry_reg > ENTRY_MAX, "entry above 9999")
  `CESS_ASSERT(a_timer_running, clk, rst, (mode != MODE_IDLE) |-> (wait_timer != '0), "timer zero while moving")
  `CESS_ASSERT(a_timer_idle, clk, rst, (mode == MODE_IDLE) |-> (wait_timer == '0), "timer live while idle")
  `CESS_ASSERT(a_no_idle_to_rev, clk, rst, (mode == MODE_IDLE) |=> (mode != MODE_REV), "reverse entered from idle")

endmodule

/* sv/code_entry_stepper_sweep_top.sv */
// Keypad code entry with a stepper sweep.
// Input channel (in_valid, in_stall, in_word): each word is a decoded key
// (func 0) or a one-millisecond tick (func 1). Output channel (out_valid,
// out_stall, out_word): exactly one result word per input word, carrying
// the entry shown to the user, the coil drive, the step position and a
// busy flag, all as they stand after that input word.
// A result is registered when its input word is accepted and shows in the
// next cycle. A new input word can be accepted every cycle while in_stall
// is low, set by the single state update between input and result register.
// When the receiver stalls, the result register holds its word and in_stall
// rises, so no further input word is taken until the result is moved.
// The configuration port writes one register per cycle with cfg_we high;
// index 0 unlock code, 1 travel steps, 2 step ticks, 3 dwell ticks.
// Write it only while the block is idle.
// Reset (rst, synchronous) restores the default registers, clears the entry,
// the latched value, position and coil drive, and empties the result
// register.
module code_entry_stepper_sweep_top
  import cess_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_word,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_addr,
  input  logic [EntryWidth-1:0]  cfg_data
);

  cfg_t cfg;
  out_t res;
  logic fire;

  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unlock_code  <= UNLOCK_CODE_RST;
      cfg.travel_steps <= TRAVEL_STEPS_RST;
      cfg.step_ticks   <= STEP_TICKS_RST;
      cfg.dwell_ticks  <= DWELL_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_UNLOCK_CODE:  cfg.unlock_code  <= cfg_data;
        REG_TRAVEL_STEPS: cfg.travel_steps <= cfg_data[PosWidth-1:0];
        REG_STEP_TICKS:   cfg.step_ticks   <= cfg_data[TickWidth-1:0];
        REG_DWELL_TICKS:  cfg.dwell_ticks  <= cfg_data[TickWidth-1:0];
        default: ;
      endcase
    end
  end

  cess_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (in_word),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= res;
    end
  end

endmodule
